/* hdl/stcp_pkg.sv */
// stcp_pkg: shared types, register codes and channel arithmetic for the
// palette word to host pixel converter. No dependencies.

package stcp_pkg;

  // Field widths
  localparam int unsigned COLOR_W  = 12;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEVEL_W  = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_CONTRAST   = 3'd1,
    REG_BPP        = 3'd2,
    REG_FIVE55     = 3'd3,
    REG_BLUE_BIT8  = 3'd4
  } cfg_reg_t;

  // Pixel format codes
  localparam logic [BPP_W-1:0] BPP_16 = 3'd2;
  localparam logic [BPP_W-1:0] BPP_24 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

  // One channel: rotate nibble into bits 7..4, apply gain (contrast + 256) / 256,
  // add brightness and clamp to 0..255.
  function automatic logic [LEVEL_W-1:0] channel_level(
    input logic [3:0]                 nib,
    input logic signed [OFFSET_W-1:0] contrast,
    input logic signed [OFFSET_W-1:0] brightness
  );
    logic [7:0]         raw;
    logic [8:0]         gain;
    logic [16:0]        prod;
    logic signed [10:0] lvl;
    logic [LEVEL_W-1:0] res;
    raw  = {nib[2:0], nib[3], 4'b0000};
    // contrast + 256 over 0..511 is the contrast with its sign bit flipped
    gain = {~contrast[8], contrast[7:0]};
    prod = 17'(raw) * 17'(gain);
    lvl  = $signed({2'b00, prod[16:8]}) + 11'(brightness);
    if (lvl[10]) begin
      res = '0;
    end else if (lvl[9:8] != 2'b00) begin
      res = LEVEL_MAX;
    end else begin
      res = lvl[7:0];
    end
    return res;
  endfunction

endpackage

/* hdl/st_color_to_pixel_converter_core.sv */
// st_color_to_pixel_converter_core: palette word to packed host pixel, two-stage
// pipeline with configuration registers. Depends on stcp_pkg.

// Usage
//   Input channel  : st_color with in_valid / in_ready, one 12-bit palette word
//                    per transfer (red 11..8, green 7..4, blue 3..0).
//   Output channel : pixel_value with out_valid / out_ready, one 32-bit packed
//                    pixel per input word, in input order.
//   Config channel : cfg_index / cfg_data with cfg_valid / cfg_ready; always
//                    ready. Index 0 brightness, 1 contrast, 2 bytes per pixel,
//                    3 555 select, 4 blue at bit eight; other indexes ignored.
//                    Write only while the pipeline is empty.
//   Path           : from input transfer to out_valid through the input
//                    register, then the result register.
//   Throughput     : one word per cycle while out_ready is high; the per-channel
//                    8x9 multiply, add and clamp sit between the input register
//                    and the result register.
//   Stall          : when out_ready is low the result holds; the input register
//                    still takes one further word, then in_ready drops.
//   Reset          : rst (synchronous) empties both stages and restores the
//                    defaults: zero offsets, 32-bit format, 565, no shift.

module st_color_to_pixel_converter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [stcp_pkg::COLOR_W-1:0]         st_color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [stcp_pkg::PIXEL_W-1:0]         pixel_value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stcp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stcp_pkg::OFFSET_W-1:0]        cfg_data
);

  // Configuration registers
  logic signed [stcp_pkg::OFFSET_W-1:0] brightness_offset;
  logic signed [stcp_pkg::OFFSET_W-1:0] contrast_offset;
  logic [stcp_pkg::BPP_W-1:0]           bytes_per_pixel;
  logic                                 use_five_five_five;
  logic                                 blue_at_bit_eight;

  // Pipeline registers
  logic                                 s1_valid;
  logic [stcp_pkg::COLOR_W-1:0]         s1_color;
  logic                                 out_load;

  logic [stcp_pkg::LEVEL_W-1:0]         lvl_r, lvl_g, lvl_b;
  logic [15:0]                          word16;
  logic [stcp_pkg::PIXEL_W-1:0]         pixel_next;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_offset  <= '0;
      contrast_offset    <= '0;
      bytes_per_pixel    <= stcp_pkg::BPP_RESET;
      use_five_five_five <= 1'b0;
      blue_at_bit_eight  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (stcp_pkg::cfg_reg_t'(cfg_index))
        stcp_pkg::REG_BRIGHTNESS: brightness_offset  <= $signed(cfg_data);
        stcp_pkg::REG_CONTRAST:   contrast_offset    <= $signed(cfg_data);
        stcp_pkg::REG_BPP:        bytes_per_pixel    <= cfg_data[stcp_pkg::BPP_W-1:0];
        stcp_pkg::REG_FIVE55:     use_five_five_five <= cfg_data[0];
        stcp_pkg::REG_BLUE_BIT8:  blue_at_bit_eight  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: result stage loads when empty or being drained
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_color <= st_color;
    end
  end

  // Channel levels
  always_comb begin
    lvl_r = stcp_pkg::channel_level(s1_color[11:8], contrast_offset, brightness_offset);
    lvl_g = stcp_pkg::channel_level(s1_color[7:4],  contrast_offset, brightness_offset);
    lvl_b = stcp_pkg::channel_level(s1_color[3:0],  contrast_offset, brightness_offset);
  end

  // Pixel packing
  always_comb begin
    if (use_five_five_five) begin
      word16 = {1'b0, lvl_r[7:3], lvl_g[7:3], lvl_b[7:3]};
    end else begin
      word16 = {lvl_r[7:3], lvl_g[7:2], lvl_b[7:3]};
    end
    if (bytes_per_pixel == stcp_pkg::BPP_16) begin
      pixel_next = {word16, word16};
    end else if (bytes_per_pixel == stcp_pkg::BPP_24) begin
      pixel_next = {lvl_b, lvl_r, lvl_g, lvl_b};
    end else if (blue_at_bit_eight) begin
      pixel_next = {lvl_r, lvl_g, lvl_b, 8'h00};
    end else begin
      pixel_next = {8'h00, lvl_r, lvl_g, lvl_b};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_value <= pixel_next;
    end
  end

endmodule

/* hdl/stcp_checker.sv */
// stcp_checker: port-level assertions for st_color_to_pixel_converter_core,
// attached by bind. Depends on stcp_pkg for widths.

module stcp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [stcp_pkg::PIXEL_W-1:0]  pixel_value
);

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_value))
    else $error("stalled result changed or dropped");

  // A new result needs a matching input transfer ahead of it, through the input register
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching input transfer");

  // An empty result stage never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while result stage empty");

endmodule

bind st_color_to_pixel_converter_core stcp_checker u_stcp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_value (pixel_value)
);

/* sim/st_color_pixel_checker.sv */
// st_color_pixel_checker: watches the config, palette and pixel channels of the
// converter, predicts each packed pixel and compares it. Depends on stcp_pkg.
`timescale 1ns / 1ps

module st_color_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [stcp_pkg::COLOR_W-1:0]   st_color,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [stcp_pkg::PIXEL_W-1:0]   pixel_value,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [stcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stcp_pkg::OFFSET_W-1:0]  cfg_data,
  output int                             mismatches,
  output int                             pixels_pending,
  output int                             pixels_checked
);

  // Shadow copy of the converter settings
  logic signed [stcp_pkg::OFFSET_W-1:0] bright_q;
  logic signed [stcp_pkg::OFFSET_W-1:0] contrast_q;
  logic [stcp_pkg::BPP_W-1:0]           bpp_q;
  logic                                 five55_q;
  logic                                 blue8_q;

  logic [stcp_pkg::PIXEL_W-1:0] pixel_due[$];
  int                           err_total = 0;
  int                           seen_total = 0;

  // Nibble to 0..255 level: rotate, gain, brightness, clamp
  function automatic logic [stcp_pkg::LEVEL_W-1:0] scale_level(input logic [3:0] nib);
    int base;
    int lvl;
    base = int'({nib[2:0], nib[3]}) * 16;
    lvl  = (base * (int'(contrast_q) + 256)) / 256;
    lvl += int'(bright_q);
    if (lvl < 0) begin
      lvl = 0;
    end else if (lvl > 255) begin
      lvl = 255;
    end
    return lvl[stcp_pkg::LEVEL_W-1:0];
  endfunction

  // Pack the three levels in the current host format
  function automatic logic [stcp_pkg::PIXEL_W-1:0] expected_pixel(
    input logic [stcp_pkg::COLOR_W-1:0] color
  );
    logic [stcp_pkg::LEVEL_W-1:0] r, g, b;
    logic [15:0]                  w16;
    logic [stcp_pkg::PIXEL_W-1:0] px;
    r = scale_level(color[11:8]);
    g = scale_level(color[7:4]);
    b = scale_level(color[3:0]);
    case (bpp_q)
      stcp_pkg::BPP_16: begin
        w16 = five55_q ? {1'b0, r[7:3], g[7:3], b[7:3]} : {r[7:3], g[7:2], b[7:3]};
        px  = {w16, w16};
      end
      stcp_pkg::BPP_24: px = {b, r, g, b};
      default: px = blue8_q ? {r, g, b, 8'h00} : {8'h00, r, g, b};
    endcase
    return px;
  endfunction

  task automatic flag_error(input string what, input logic [stcp_pkg::PIXEL_W-1:0] want,
                            input logic [stcp_pkg::PIXEL_W-1:0] got);
    err_total++;
    if (err_total <= 10) begin
      $display("[%0t] %s: expected %08h, got %08h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bright_q   = '0;
      contrast_q = '0;
      bpp_q      = stcp_pkg::BPP_RESET;
      five55_q   = 1'b0;
      blue8_q    = 1'b0;
      pixel_due.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stcp_pkg::REG_BRIGHTNESS: bright_q   = cfg_data;
          stcp_pkg::REG_CONTRAST:   contrast_q = cfg_data;
          stcp_pkg::REG_BPP:        bpp_q      = cfg_data[stcp_pkg::BPP_W-1:0];
          stcp_pkg::REG_FIVE55:     five55_q   = cfg_data[0];
          stcp_pkg::REG_BLUE_BIT8:  blue8_q    = cfg_data[0];
          default: ;
        endcase
      end
      // pixel transfer against the oldest prediction
      if (out_valid && out_ready) begin
        seen_total++;
        if (pixel_due.size() == 0) begin
          flag_error("pixel with none outstanding", '0, pixel_value);
        end else if (pixel_value !== pixel_due[0]) begin
          flag_error("pixel mismatch", pixel_due[0], pixel_value);
          void'(pixel_due.pop_front());
        end else begin
          void'(pixel_due.pop_front());
        end
      end
      // palette transfer
      if (in_valid && in_ready) begin
        pixel_due.push_back(expected_pixel(st_color));
      end
    end
    mismatches     <= err_total;
    pixels_pending <= pixel_due.size();
    pixels_checked <= seen_total;
  end

endmodule

/* sim/st_color_to_pixel_converter_core_tb.sv */
// st_color_to_pixel_converter_core_tb: stimulus and verdict for the palette to
// pixel converter. Depends on stcp_pkg, the core and st_color_pixel_checker.
`timescale 1ns / 1ps

module st_color_to_pixel_converter_core_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_WORDS = 75;

  localparam logic [stcp_pkg::BPP_W-1:0]    BPP_NONE   = 3'd0;
  localparam logic [stcp_pkg::BPP_W-1:0]    BPP_8      = 3'd1;
  localparam logic [stcp_pkg::BPP_W-1:0]    BPP_32     = stcp_pkg::BPP_RESET;
  localparam logic [stcp_pkg::OFFSET_W-1:0] OFFSET_MIN = 9'h100;
  localparam logic [stcp_pkg::OFFSET_W-1:0] OFFSET_MAX = 9'h0FF;

  logic                           clk;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [stcp_pkg::COLOR_W-1:0]   st_color    = '0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic [stcp_pkg::PIXEL_W-1:0]   pixel_value;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [stcp_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [stcp_pkg::OFFSET_W-1:0]  cfg_data    = '0;

  int   mismatches;
  int   pixels_pending;
  int   pixels_checked;
  logic steady_flow   = 1'b0;
  int   words_sent    = 0;
  int   settings_used = 0;
  int   cycles        = 0;

  st_color_to_pixel_converter_core u_top (
    .clk, .rst, .in_valid, .in_ready, .st_color, .out_valid, .out_ready,
    .pixel_value, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  st_color_pixel_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .st_color, .out_valid, .out_ready,
    .pixel_value, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pixels_pending, .pixels_checked
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels outstanding", cycles, pixels_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [stcp_pkg::OFFSET_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return OFFSET_MIN;
    if (r < 40) return OFFSET_MAX;
    if (r < 50) return '0;
    return stcp_pkg::OFFSET_W'($urandom_range(0, 511));
  endfunction

  // Pixel sink back-pressure
  initial begin
    @(negedge rst);
    forever begin
      out_ready <= 1'b1;
      repeat (steady_flow ? 8 : $urandom_range(1, 12)) @(posedge clk);
      if (!steady_flow) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // One palette transfer, with a random gap ahead of it
  task automatic send_color(input logic [stcp_pkg::COLOR_W-1:0] color);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    st_color <= color;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [stcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [stcp_pkg::OFFSET_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Settings only change with the pipeline empty
  task automatic set_format(input logic [stcp_pkg::OFFSET_W-1:0] bright,
                            input logic [stcp_pkg::OFFSET_W-1:0] contrast,
                            input logic [stcp_pkg::BPP_W-1:0] bpp, input logic five55,
                            input logic blue8, input logic spare_write);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(stcp_pkg::REG_BRIGHTNESS, bright);
    write_reg(stcp_pkg::REG_CONTRAST, contrast);
    write_reg(stcp_pkg::REG_BPP, {6'($urandom_range(0, 63)), bpp});
    write_reg(stcp_pkg::REG_FIVE55, {8'($urandom_range(0, 255)), five55});
    write_reg(stcp_pkg::REG_BLUE_BIT8, {8'($urandom_range(0, 255)), blue8});
    // writes to indexes past the last register must change nothing
    if (spare_write) begin
      write_reg(stcp_pkg::CFG_IDX_W'($urandom_range(int'(stcp_pkg::REG_BLUE_BIT8) + 1, 7)),
                stcp_pkg::OFFSET_W'($urandom_range(0, 511)));
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [stcp_pkg::COLOR_W-1:0] basics[7];
    logic [stcp_pkg::BPP_W-1:0]   bpp_pick;
    int                           r;

    basics = '{12'h000, 12'hFFF, 12'h888, 12'h777, 12'h111, 12'h248, 12'h1E3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: 32-bit, no shift, unity gain
    foreach (basics[i]) send_color(basics[i]);

    // Clamp high, 565
    set_format(OFFSET_MAX, OFFSET_MAX, stcp_pkg::BPP_16, 1'b0, 1'b0, 1'b0);
    send_color(12'hFFF);
    send_color(12'h000);
    send_color(12'h5A5);
    // Clamp low and zero gain, 555
    set_format(OFFSET_MIN, OFFSET_MIN, stcp_pkg::BPP_16, 1'b1, 1'b1, 1'b0);
    send_color(12'hFFF);
    send_color(12'h888);
    // 24-bit with the blue wrap
    set_format(9'h040, 9'h1C0, stcp_pkg::BPP_24, 1'b1, 1'b1, 1'b0);
    send_color(12'hFFF);
    send_color(12'h123);
    send_color(12'h00F);
    // 8-bit and 32-bit with the shift
    set_format(9'h1F0, 9'h080, BPP_8, 1'b0, 1'b1, 1'b0);
    send_color(12'h321);
    send_color(12'hFFF);
    set_format('0, '0, BPP_32, 1'b1, 1'b1, 1'b1);
    send_color(12'hABC);
    // Unlisted formats pack as 32-bit
    set_format(9'h010, 9'h0FF, BPP_NONE, 1'b0, 1'b0, 1'b1);
    send_color(12'h9C6);
    for (int k = int'(BPP_32) + 1; k < 8; k++) begin
      set_format(pick_offset(), pick_offset(), stcp_pkg::BPP_W'(k), 1'b1, k[0], 1'b1);
      send_color(stcp_pkg::COLOR_W'($urandom_range(0, 4095)));
    end

    // Random phases, each with its own settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(0, 9);
      bpp_pick = (r < 8) ? stcp_pkg::BPP_W'($urandom_range(1, 4))
                         : stcp_pkg::BPP_W'($urandom_range(0, 7));
      if (p == 0) begin
        set_format(OFFSET_MAX, OFFSET_MAX, stcp_pkg::BPP_16, 1'b0, 1'b1, 1'b0);
      end else if (p == 1) begin
        set_format(OFFSET_MIN, OFFSET_MIN, stcp_pkg::BPP_24, 1'b1, 1'b0, 1'b0);
      end else begin
        set_format(pick_offset(), pick_offset(), bpp_pick, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end
      steady_flow = (p % 4 == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_color(12'h000);
        end else if (r < 10) begin
          send_color(12'hFFF);
        end else begin
          send_color(stcp_pkg::COLOR_W'($urandom_range(0, 4095)));
        end
      end
      steady_flow = 1'b0;
    end

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Summary: %0d palette words across %0d register settings, %0d pixels compared",
             words_sent, settings_used, pixels_checked);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/stcp_pkg.sv
hdl/st_color_to_pixel_converter_core.sv
hdl/stcp_checker.sv
sim/st_color_pixel_checker.sv
sim/st_color_to_pixel_converter_core_tb.sv
